@@ design/sprc_pkg.sv @@
// shared constants and types of the packet receiver with sum16 checksum
package sprc_pkg;

	localparam logic        OP_BYTE      = 1'b0;
	localparam logic        OP_TICK      = 1'b1;

	localparam logic        KIND_PAYLOAD = 1'b0;
	localparam logic        KIND_REPORT  = 1'b1;

	localparam logic [1:0]  OC_OK        = 2'd0;
	localparam logic [1:0]  OC_CHECKSUM  = 2'd1;
	localparam logic [1:0]  OC_TIMEOUT   = 2'd2;
	localparam logic [1:0]  OC_SHORT     = 2'd3;

	localparam logic [15:0] TIMEOUT_RESET = 16'd100;
	localparam logic [15:0] TIMEOUT_MIN   = 16'd1;

	localparam logic [8:0]  IDX_OPCODE   = 9'd1;
	localparam logic [8:0]  IDX_STATUS   = 9'd3;
	localparam logic [8:0]  IDX_PAYLOAD  = 9'd4;
	localparam logic [7:0]  MIN_LENGTH   = 8'd4;

	typedef struct packed {
		logic       result_kind;
		logic [7:0] payload_byte;
		logic [7:0] packet_opcode;
		logic [7:0] packet_status;
		logic [7:0] payload_length;
		logic [1:0] outcome;
	} result_t;

endpackage

@@ design/sprc_deframe.sv @@
// frame tracking, checksum accumulation and result forming for one beat
module sprc_deframe (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [15:0]       cfg_data,
	input  logic              fire,
	input  logic              opcode,
	input  logic [7:0]        rx_byte,
	output logic              has_result,
	output sprc_pkg::result_t result
);

	logic        receiving_q,  receiving_d;
	logic [8:0]  byte_index_q, byte_index_d;
	logic [7:0]  length_q,     length_d;
	logic [15:0] sum_q,        sum_d;
	logic [7:0]  chk_high_q,   chk_high_d;
	logic [7:0]  opcode_q,     opcode_d;
	logic [7:0]  status_q,     status_d;
	logic [15:0] idle_q,       idle_d;
	logic [15:0] timeout_q;

	logic [15:0] limit;
	logic [15:0] idle_inc;
	logic [15:0] expect_sum;
	logic [15:0] got_sum;
	logic [7:0]  report_len;
	logic [8:0]  length_ext;

	always_comb begin
		limit      = (timeout_q == 16'd0) ? sprc_pkg::TIMEOUT_MIN : timeout_q;
		idle_inc   = idle_q + 16'd1;
		expect_sum = 16'd0 - sum_q;
		got_sum    = {chk_high_q, rx_byte};
		length_ext = {1'b0, length_q};
		report_len = (length_q >= sprc_pkg::MIN_LENGTH) ?
			(length_q - sprc_pkg::MIN_LENGTH) : 8'd0;
	end

	always_comb begin
		receiving_d  = receiving_q;
		byte_index_d = byte_index_q;
		length_d     = length_q;
		sum_d        = sum_q;
		chk_high_d   = chk_high_q;
		opcode_d     = opcode_q;
		status_d     = status_q;
		idle_d       = idle_q;
		has_result   = 1'b0;
		result       = '0;

		priority if (opcode == sprc_pkg::OP_TICK) begin
			if (receiving_q) begin
				if (idle_inc >= limit) begin
					receiving_d           = 1'b0;
					byte_index_d          = 9'd0;
					idle_d                = 16'd0;
					has_result            = 1'b1;
					result.result_kind    = sprc_pkg::KIND_REPORT;
					result.packet_opcode  = opcode_q;
					result.packet_status  = status_q;
					result.payload_length = report_len;
					result.outcome        = sprc_pkg::OC_TIMEOUT;
				end else begin
					idle_d = idle_inc;
				end
			end
		end else if (!receiving_q) begin
			// length byte opens a new frame
			receiving_d  = 1'b1;
			byte_index_d = 9'd1;
			length_d     = rx_byte;
			sum_d        = {8'd0, rx_byte};
			chk_high_d   = 8'd0;
			opcode_d     = 8'd0;
			status_d     = 8'd0;
			idle_d       = 16'd0;
		end else if (byte_index_q < length_ext) begin
			idle_d       = 16'd0;
			sum_d        = sum_q + {8'd0, rx_byte};
			byte_index_d = byte_index_q + 9'd1;
			if (byte_index_q == sprc_pkg::IDX_OPCODE) begin
				opcode_d = rx_byte;
			end
			if (byte_index_q == sprc_pkg::IDX_STATUS) begin
				status_d = rx_byte;
			end
			if (byte_index_q >= sprc_pkg::IDX_PAYLOAD) begin
				has_result          = 1'b1;
				result.result_kind  = sprc_pkg::KIND_PAYLOAD;
				result.payload_byte = rx_byte;
			end
		end else if (byte_index_q == length_ext) begin
			idle_d       = 16'd0;
			chk_high_d   = rx_byte;
			byte_index_d = byte_index_q + 9'd1;
		end else begin
			// low checksum byte closes the frame
			idle_d                = 16'd0;
			receiving_d           = 1'b0;
			byte_index_d          = 9'd0;
			has_result            = 1'b1;
			result.result_kind    = sprc_pkg::KIND_REPORT;
			result.packet_opcode  = opcode_q;
			result.packet_status  = status_q;
			result.payload_length = report_len;
			if (length_q < sprc_pkg::MIN_LENGTH) begin
				result.outcome = sprc_pkg::OC_SHORT;
			end else if (expect_sum == got_sum) begin
				result.outcome = sprc_pkg::OC_OK;
			end else begin
				result.outcome = sprc_pkg::OC_CHECKSUM;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= sprc_pkg::TIMEOUT_RESET;
		end else if (cfg_we) begin
			timeout_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			receiving_q  <= 1'b0;
			byte_index_q <= 9'd0;
			length_q     <= 8'd0;
			sum_q        <= 16'd0;
			chk_high_q   <= 8'd0;
			opcode_q     <= 8'd0;
			status_q     <= 8'd0;
			idle_q       <= 16'd0;
		end else if (fire) begin
			receiving_q  <= receiving_d;
			byte_index_q <= byte_index_d;
			length_q     <= length_d;
			sum_q        <= sum_d;
			chk_high_q   <= chk_high_d;
			opcode_q     <= opcode_d;
			status_q     <= status_d;
			idle_q       <= idle_d;
		end
	end

endmodule

@@ design/serial_packet_receiver_checksum_core.sv @@
// top level of the length-prefixed packet receiver with sum16 checksum
// a beat passes the input register, then the frame update and the
//   result register, before its result is on the outputs
// throughput: one beat per cycle, unless a result waits on out_stall
// reset: arst_n clears the frame state, both registers' valid flags,
//   and loads the inter-byte timeout with 100 ticks
module serial_packet_receiver_checksum_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        opcode,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        result_kind,
	output logic [7:0]  payload_byte,
	output logic [7:0]  packet_opcode,
	output logic [7:0]  packet_status,
	output logic [7:0]  payload_length,
	output logic [1:0]  outcome,
	output logic        last
);

	logic              valid_s1;
	logic              opcode_s1;
	logic [7:0]        rx_byte_s1;
	logic              has_result;
	sprc_pkg::result_t result;
	logic              advance;
	logic              out_free;
	logic              out_valid_q;
	sprc_pkg::result_t out_q;

	assign out_free = !out_valid_q || !out_stall;
	assign advance  = valid_s1 && (out_free || !has_result);
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			opcode_s1  <= opcode;
			rx_byte_s1 <= rx_byte;
		end
	end

	sprc_deframe u_deframe (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_data   (cfg_data),
		.fire       (advance),
		.opcode     (opcode_s1),
		.rx_byte    (rx_byte_s1),
		.has_result (has_result),
		.result     (result)
	);

	// result register, loaded only when the beat gives a result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && has_result) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && has_result) begin
			out_q <= result;
		end
	end

	assign out_valid      = out_valid_q;
	assign result_kind    = out_q.result_kind;
	assign payload_byte   = out_q.payload_byte;
	assign packet_opcode  = out_q.packet_opcode;
	assign packet_status  = out_q.packet_status;
	assign payload_length = out_q.payload_length;
	assign outcome        = out_q.outcome;
	assign last           = out_q.result_kind;

	a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && has_result && out_valid_q && out_stall))
		else $error("input stalled without a blocked result");

	a_held_beat_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(opcode_s1) && $stable(rx_byte_s1)))
		else $error("waiting beat lost or changed");

	a_payload_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && result_kind == sprc_pkg::KIND_PAYLOAD) |->
		(outcome == sprc_pkg::OC_OK && payload_length == 8'd0 && packet_opcode == 8'd0))
		else $error("payload beat carries report fields");

	a_short_no_length: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && last && outcome == sprc_pkg::OC_SHORT) |-> (payload_length == 8'd0))
		else $error("short frame reports a payload length");

endmodule
